@@ rtl/tpcsa_pkg.sv @@
// Shared constants, codes and word types for the two-priority slot allocator.
package tpcsa_pkg;

  localparam int SLOTS  = 1024;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int NUM_W  = 11;

  localparam logic [NUM_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [1:0] HOLD_FREE = 2'd0;
  localparam logic [1:0] HOLD_LOW  = 2'd1;
  localparam logic [1:0] HOLD_HIGH = 2'd2;

  localparam logic [1:0] FUNC_ALLOC_LOW  = 2'd0;
  localparam logic [1:0] FUNC_ALLOC_HIGH = 2'd1;
  localparam logic [1:0] FUNC_FREE       = 2'd2;
  localparam logic [1:0] FUNC_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [NUM_W-1:0] run_length;
    logic [NUM_W-1:0] first_slot;
    logic [NUM_W-1:0] last_slot;
  } in_word_t;

  typedef struct packed {
    logic             status;
    logic [NUM_W-1:0] start_slot;
  } out_word_t;

endpackage

@@ rtl/tpcsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tpcsa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/two_priority_contiguous_slot_allocator_top.sv @@
// Two-priority contiguous slot allocator: slot table scanner and range writer.
// The scan reads one slot per cycle; a high allocate that finds no free run rescans with
// low holders open to pre-emption. A free is clipped to slots 1..n before its range is
// written; an empty free, a rejected or an unused word goes straight to the result. One
// word at a time, the next accepted only after the result is taken. Reset and each count
// write start a clearing pass over all 1024 slots.
module two_priority_contiguous_slot_allocator_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tpcsa_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tpcsa_pkg::out_word_t  out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [10:0]           cfg_data
);
  import tpcsa_pkg::*;

  // Sequencer states. CLEAR sweeps the table, SCAN streams slots through the
  // compare unit, MARK writes a range, OUT holds the result word.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state;
  logic [NUM_W-1:0]  cfg;
  logic [ADDR_W-1:0] clr;
  logic [1:0]        func;
  logic [NUM_W-1:0]  len;
  logic [1:0]        limit;
  logic [NUM_W-1:0]  ra;
  logic              dv;
  logic [ADDR_W-1:0] di;
  logic [NUM_W-1:0]  count;
  logic [ADDR_W-1:0] wa;
  logic [NUM_W-1:0]  rem;
  logic [1:0]        who;
  logic              res_status;
  logic [NUM_W-1:0]  res_start;

  logic [NUM_W-1:0]  n;
  logic [NUM_W-1:0]  di_ext;
  logic [NUM_W-1:0]  start_m1;
  logic [NUM_W-1:0]  free_f;
  logic [NUM_W-1:0]  free_l;
  logic [NUM_W-1:0]  free_f_m1;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [1:0]        wdata;
  logic [1:0]        rdata;

  // The managed count is the register clipped to the table size.
  assign n         = (cfg > NUM_W'(SLOTS)) ? NUM_W'(SLOTS) : cfg;
  assign di_ext    = NUM_W'(di);
  assign start_m1  = di_ext + NUM_W'(1) - len;
  assign free_f    = (in_word.first_slot < NUM_W'(1)) ? NUM_W'(1) : in_word.first_slot;
  assign free_l    = (in_word.last_slot > n) ? n : in_word.last_slot;
  assign free_f_m1 = free_f - NUM_W'(1);

  assign we    = (state == S_CLEAR) || (state == S_MARK);
  assign waddr = (state == S_CLEAR) ? clr : wa;
  assign wdata = (state == S_CLEAR) ? HOLD_FREE : who;

  tpcsa_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // A count write is only taken while no word is in flight, and it wins over
  // an input word offered in the same cycle, which is stalled meanwhile.
  assign cfg_ready           = (state == S_IDLE) || (state == S_CLEAR);
  assign in_stall            = (state != S_IDLE) || cfg_valid;
  assign out_word.status     = res_status;
  assign out_word.start_slot = res_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cfg       <= CFG_RESET;
      out_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      // A new count frees every slot, so the sweep starts again.
      cfg   <= cfg_data;
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + ADDR_W'(1);
          if (clr == ADDR_W'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func  <= in_word.func;
            len   <= in_word.run_length;
            limit <= HOLD_FREE;
            ra    <= '0;
            dv    <= 1'b0;
            count <= '0;
            res_status <= 1'b0;
            res_start  <= '0;
            if (in_word.func == FUNC_ALLOC_LOW || in_word.func == FUNC_ALLOC_HIGH) begin
              if (in_word.run_length == '0 || in_word.run_length > n) begin
                res_status <= 1'b1;
                out_valid  <= 1'b1;
                state      <= S_OUT;
              end else begin
                state <= S_SCAN;
              end
            end else if (in_word.func == FUNC_FREE && free_f <= free_l) begin
              wa    <= free_f_m1[ADDR_W-1:0];
              rem   <= free_l - free_f + NUM_W'(1);
              who   <= HOLD_FREE;
              state <= S_MARK;
            end else begin
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          dv <= (ra < n);
          di <= ra[ADDR_W-1:0];
          if (ra < n) begin
            ra <= ra + NUM_W'(1);
          end
          if (dv) begin
            if (rdata <= limit && count + NUM_W'(1) == len) begin
              wa         <= start_m1[ADDR_W-1:0];
              rem        <= len;
              who        <= (func == FUNC_ALLOC_LOW) ? HOLD_LOW : HOLD_HIGH;
              res_start  <= start_m1 + NUM_W'(1);
              state      <= S_MARK;
            end else begin
              if (rdata <= limit) begin
                count <= count + NUM_W'(1);
              end else begin
                count <= '0;
              end
              if (di_ext == n - NUM_W'(1)) begin
                if (func == FUNC_ALLOC_HIGH && limit == HOLD_FREE) begin
                  // No free run: rescan allowing low holders to be pre-empted.
                  limit <= HOLD_LOW;
                  ra    <= '0;
                  dv    <= 1'b0;
                  count <= '0;
                end else begin
                  res_status <= 1'b1;
                  out_valid  <= 1'b1;
                  state      <= S_OUT;
                end
              end
            end
          end
        end
        S_MARK: begin
          wa  <= wa + ADDR_W'(1);
          rem <= rem - NUM_W'(1);
          if (rem == NUM_W'(1)) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
